@@ rtl/rect_scroll_framebuffer_defines.svh @@
// assertion macros for the frame store block
`ifndef RECT_SCROLL_FRAMEBUFFER_DEFINES_SVH
`define RECT_SCROLL_FRAMEBUFFER_DEFINES_SVH
// implication checked on every edge outside reset
`define RSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the following cycle
`define RSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/rsf_pkg.sv @@
// types and constants of the frame store block
`timescale 1ns / 1ps
package rsf_pkg;
	localparam logic [3:0] OP_WRITE = 4'd0;
	localparam logic [3:0] OP_READ  = 4'd1;
	localparam logic [3:0] OP_FILL  = 4'd2;
	localparam logic [3:0] OP_UP    = 4'd3;
	localparam logic [3:0] OP_DOWN  = 4'd4;
	localparam logic [3:0] OP_LEFT  = 4'd5;
	localparam logic [3:0] OP_RIGHT = 4'd6;
	localparam logic [3:0] OP_LAST  = 4'd10;
	localparam logic [3:0] OP_WRAP0 = 4'd7;
	localparam logic [9:0] LINE_WIDTH_RST = 10'd320;
	localparam logic [8:0] LINE_COUNT_RST = 9'd240;
	localparam logic [0:0] REG_LINE_WIDTH = 1'b0;
	localparam logic [0:0] REG_LINE_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_ONE, ST_FILL, ST_LOAD, ST_LOADW, ST_STORE, ST_NEXT, ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0] read_color;
		logic       range_error;
	} result_t;
endpackage

@@ rtl/rsf_if.sv @@
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface rsf_cmd_if;
	logic       valid;
	logic       ready;
	logic [3:0] operation;
	logic [16:0] pixel_index;
	logic [8:0] rect_x;
	logic [7:0] rect_y;
	logic [9:0] rect_width;
	logic [8:0] rect_height;
	logic [9:0] shift_amount;
	logic [7:0] color;
	modport source(output valid, operation, pixel_index, rect_x, rect_y, rect_width,
		rect_height, shift_amount, color, input ready);
	modport sink(input valid, operation, pixel_index, rect_x, rect_y, rect_width,
		rect_height, shift_amount, color, output ready);
endinterface

interface rsf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_color;
	logic       range_error;
	modport source(output valid, read_color, range_error, input ready);
	modport sink(input valid, read_color, range_error, output ready);
endinterface

@@ rtl/rsf_store.sv @@
// frame memory and line scratch memory, both with registered reads
`timescale 1ns / 1ps
module rsf_store import rsf_pkg::*; #(
	parameter int DEPTH = 131072,
	parameter int LINE_DEPTH = 512,
	parameter int CB = 8
) (
	input  logic                          clk,
	input  logic                          fwe,
	input  logic [$clog2(DEPTH)-1:0]      faddr,
	input  logic [CB-1:0]                 fwdata,
	output logic [CB-1:0]                 frdata,
	input  logic                          lwe,
	input  logic [$clog2(LINE_DEPTH)-1:0] lwaddr,
	input  logic [CB-1:0]                 lwdata,
	input  logic [$clog2(LINE_DEPTH)-1:0] lraddr,
	output logic [CB-1:0]                 lrdata
);
	logic [CB-1:0] frame_mem [DEPTH];
	logic [CB-1:0] line_mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (fwe) frame_mem[faddr] <= fwdata;
		frdata <= frame_mem[faddr];
	end

	always_ff @(posedge clk) begin
		if (lwe) line_mem[lwaddr] <= lwdata;
		lrdata <= line_mem[lraddr];
	end
endmodule

@@ rtl/rect_scroll_framebuffer.sv @@
// Rectangle-scroll frame store. One command per beat; one result beat per command.
// Fill sweeps the frame in use, one pixel a cycle. A scroll handles the rectangle
// one line (a column for up/down, a row for left/right) at a time: the line is
// copied into a scratch memory, one pixel a cycle, then written back shifted,
// each pixel as a scratch read and then a frame write; the single frame memory
// port and the registered scratch read set this order.
// After reset the frame memory is cleared over all MAX_WIDTH*MAX_HEIGHT pixels;
// no command is taken during this pass.
`timescale 1ns / 1ps
`include "rect_scroll_framebuffer_defines.svh"
module rect_scroll_framebuffer import rsf_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 256,
	parameter int COLOR_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	rsf_cmd_if.sink     cmd,
	rsf_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int LD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int LW = $clog2(LD);
	localparam int CW = $clog2(LD + 1) + 1;
	localparam int PW = AW + 2;
	localparam int CB_W = COLOR_BITS;

	// configuration
	logic [9:0] line_width_q;
	logic [8:0] line_count_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			line_count_q <= LINE_COUNT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_LINE_WIDTH) line_width_q <= pwdata[9:0];
			else line_count_q <= pwdata[8:0];
		end
	end
	always_comb begin
		if (paddr[2] == REG_LINE_WIDTH) prdata = {22'd0, line_width_q};
		else prdata = {23'd0, line_count_q};
	end

	logic [CW-1:0] fw, fh;
	always_comb begin
		fw = (line_width_q == 10'd0) ? CW'(1) : CW'(line_width_q);
		if (fw > CW'(MAX_WIDTH)) fw = CW'(MAX_WIDTH);
		fh = (line_count_q == 9'd0) ? CW'(1) : CW'(line_count_q);
		if (fh > CW'(MAX_HEIGHT)) fh = CW'(MAX_HEIGHT);
	end

	// command registers
	state_t state_q, state_d;
	logic [3:0]       op_q;
	logic [CB_W-1:0]  col_q;
	logic [PW-1:0]    base_q;     // address of line start
	logic [PW-1:0]    lstep_q;    // between lines
	logic [PW-1:0]    stride_q;   // within a line
	logic [CW-1:0]    n_q, a_q, lines_q, line_q, i_q;
	logic             tstart_q, wrap_q;
	logic [PW-1:0]    addr_q;
	logic [PW-1:0]    total_q;
	result_t          res_q;
	logic             rvalid_q;

	// memory
	logic             fwe, lwe;
	logic [AW-1:0]    faddr;
	logic [CB_W-1:0]  fwdata, frdata, lrdata;
	logic [LW-1:0]    lraddr;
	logic [CW-1:0]    src;
	logic             have;

	rsf_store #(.DEPTH(DEPTH), .LINE_DEPTH(LD), .CB(CB_W)) u_store (
		.clk(clk), .fwe(fwe), .faddr(faddr), .fwdata(fwdata), .frdata(frdata),
		.lwe(lwe), .lwaddr(i_q[LW-1:0] - LW'(1)), .lwdata(frdata),
		.lraddr(lraddr), .lrdata(lrdata)
	);

	// source slot for write-back pass
	always_comb begin
		have = 1'b1;
		src = '0;
		if (tstart_q) begin
			src = i_q + a_q;
			if (src >= n_q) begin
				if (wrap_q) src = src - n_q; else have = 1'b0;
			end
		end else begin
			if (i_q >= a_q) src = i_q - a_q;
			else if (wrap_q) src = i_q + n_q - a_q;
			else have = 1'b0;
		end
		lraddr = src[LW-1:0];
	end

	// decode the incoming command
	logic [CW-1:0] rx, ry, rw, rh, amt, am;
	logic          serr, vert;
	logic [1:0]    dir;
	always_comb begin
		rx = CW'(cmd.rect_x);
		ry = CW'(cmd.rect_y);
		rw = CW'(cmd.rect_width);
		rh = CW'(cmd.rect_height);
		dir = 2'(cmd.operation - OP_UP);
		vert = !dir[1];
		serr = (rx >= fw) || (ry >= fh);
		if (rw == '0) rw = fw - rx;
		if (rh == '0) rh = fh - ry;
		if (!serr && ((rx + rw > fw) || (ry + rh > fh))) serr = 1'b1;
		amt = CW'(cmd.shift_amount);
		am = vert ? ((amt > rh) ? rh : amt) : ((amt > rw) ? rw : amt);
	end

	logic [PW-1:0] size, ypos;
	assign size = PW'(fw) * PW'(fh);
	assign ypos = PW'(ry) * PW'(fw);
	// phase of memory pipeline: read was issued last cycle
	logic rd_s1;

	assign cmd.ready = (state_q == ST_IDLE) && !rvalid_q;
	assign res.valid = rvalid_q;
	assign res.read_color = res_q.read_color;
	assign res.range_error = res_q.range_error;

	always_comb begin
		state_d = state_q;
		fwe = 1'b0;
		lwe = 1'b0;
		faddr = addr_q[AW-1:0];
		fwdata = col_q;
		case (state_q)
			ST_CLEAR: begin
				fwe = 1'b1;
				fwdata = '0;
				if (addr_q == PW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.valid && cmd.ready) begin
					if (cmd.operation inside {OP_WRITE, OP_READ}) state_d = ST_ONE;
					else if (cmd.operation == OP_FILL) state_d = ST_FILL;
					else if (cmd.operation <= OP_LAST)
						state_d = (serr || am == '0) ? ST_DONE : ST_LOAD;
					else state_d = ST_DONE;
				end
			end
			ST_ONE: begin
				fwe = (op_q == OP_WRITE) && !res_q.range_error;
				state_d = ST_DONE;
			end
			ST_FILL: begin
				fwe = (addr_q < total_q);
				if (addr_q + PW'(1) >= total_q) state_d = ST_DONE;
			end
			ST_LOAD: begin
				lwe = rd_s1;
				if (i_q == n_q) state_d = ST_LOADW;
			end
			ST_LOADW: state_d = ST_STORE;
			ST_STORE: begin
				fwe = rd_s1;
				fwdata = have ? lrdata : col_q;
				if (rd_s1 && i_q + CW'(1) == n_q) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (line_q + CW'(1) == lines_q) state_d = ST_DONE;
				else state_d = ST_LOAD;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			rvalid_q <= 1'b0;
			rd_s1 <= 1'b0;
			i_q <= '0;
			line_q <= '0;
			op_q <= '0;
			col_q <= '0;
			res_q <= '0;
			base_q <= '0;
			lstep_q <= '0;
			stride_q <= '0;
			n_q <= '0;
			a_q <= '0;
			lines_q <= '0;
			tstart_q <= 1'b0;
			wrap_q <= 1'b0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) rvalid_q <= 1'b1;
			else if (res.valid && res.ready) rvalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: addr_q <= addr_q + PW'(1);
				ST_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						op_q <= cmd.operation;
						col_q <= CB_W'(cmd.color);
						res_q.read_color <= '0;
						i_q <= '0;
						line_q <= '0;
						rd_s1 <= 1'b0;
						total_q <= size;
						wrap_q <= (cmd.operation >= OP_WRAP0);
						tstart_q <= (dir == 2'd0) || (dir == 2'd2);
						a_q <= am;
						base_q <= ypos + PW'(rx);
						if (vert) begin
							n_q <= rh; lines_q <= rw;
							stride_q <= PW'(fw); lstep_q <= PW'(1);
						end else begin
							n_q <= rw; lines_q <= rh;
							stride_q <= PW'(1); lstep_q <= PW'(fw);
						end
						if (cmd.operation inside {OP_WRITE, OP_READ}) begin
							addr_q <= PW'(cmd.pixel_index);
							res_q.range_error <= (PW'(cmd.pixel_index) >= size);
						end else if (cmd.operation == OP_FILL) begin
							addr_q <= '0;
							res_q.range_error <= 1'b0;
						end else if (cmd.operation <= OP_LAST) begin
							addr_q <= ypos + PW'(rx);
							res_q.range_error <= serr;
						end else begin
							addr_q <= '0;
							res_q.range_error <= 1'b0;
						end
					end
				end
				ST_ONE: ;
				ST_FILL: addr_q <= addr_q + PW'(1);
				ST_LOAD: begin
					// issue reads for entries 0..n-1, capture in the next cycle
					i_q <= i_q + CW'(1);
					if (i_q == n_q) begin
						addr_q <= base_q;
						rd_s1 <= 1'b0;
					end else begin
						addr_q <= addr_q + stride_q;
						rd_s1 <= 1'b1;
					end
				end
				ST_LOADW: begin
					i_q <= '0;
					rd_s1 <= 1'b0;
				end
				ST_STORE: begin
					// first cycle reads scratch, next writes
					if (!rd_s1) rd_s1 <= 1'b1;
					else begin
						rd_s1 <= 1'b0;
						i_q <= i_q + CW'(1);
						addr_q <= addr_q + stride_q;
					end
				end
				ST_NEXT: begin
					line_q <= line_q + CW'(1);
					base_q <= base_q + lstep_q;
					addr_q <= base_q + lstep_q;
					i_q <= '0;
					rd_s1 <= 1'b0;
				end
				ST_DONE: begin
					res_q.read_color <= (op_q == OP_READ && !res_q.range_error) ?
						8'(frdata) : 8'd0;
				end
				default: ;
			endcase
		end
	end

	`RSF_ASSERT_IMP(a_no_accept_busy, clk, arst_n, cmd.valid && cmd.ready, state_q == ST_IDLE && !res.valid, "command taken while busy")
	`RSF_ASSERT_NEXT(a_done_result, clk, arst_n, state_q == ST_DONE, res.valid, "no result after command")
	`RSF_ASSERT_IMP(a_no_write_idle, clk, arst_n, state_q == ST_IDLE, !fwe, "frame written while idle")
endmodule

@@ bench/tb_rect_scroll_framebuffer.sv @@
// testbench for the rectangle-scroll frame store: directed and random traffic checked against a behavioural model
`timescale 1ns / 1ps
module tb_rect_scroll_framebuffer;
	import rsf_pkg::*;

	localparam int MAXW = 512;
	localparam int MAXH = 256;
	localparam int STORE = MAXW * MAXH;
	localparam int IDLE_LIMIT = 2000000;
	localparam logic [3:0] OP_UP_W    = OP_WRAP0;
	localparam logic [3:0] OP_DOWN_W  = OP_WRAP0 + 4'd1;
	localparam logic [3:0] OP_LEFT_W  = OP_WRAP0 + 4'd2;
	localparam logic [3:0] OP_RIGHT_W = OP_WRAP0 + 4'd3;
	localparam logic [3:0] OP_SPARE_LO = OP_LAST + 4'd1;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	typedef struct {
		logic [3:0]  op;
		logic [16:0] idx;
		logic [8:0]  rx;
		logic [7:0]  ry;
		logic [9:0]  rw;
		logic [8:0]  rh;
		logic [9:0]  amt;
		logic [7:0]  col;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rsf_cmd_if cmd ();
	rsf_res_if res ();

	rect_scroll_framebuffer u_top (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .res(res.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// shadow of the block
	logic [7:0] frame_model [STORE];
	logic [7:0] line_tmp [MAXW];
	logic [9:0] width_reg = LINE_WIDTH_RST;
	logic [8:0] count_reg = LINE_COUNT_RST;

	cmd_t cmds_to_send [$];
	result_t results_due [$];
	cmd_t cur;
	int gap = 0, stall = 0, idle_cycles = 0;
	int n_cmds = 0, n_checked = 0, n_errors = 0, n_flagged = 0;
	bit no_idle = 0;

	function automatic int eff_width();
		return (width_reg == 0) ? 1 : (width_reg > MAXW) ? MAXW : int'(width_reg);
	endfunction

	function automatic int eff_height();
		return (count_reg == 0) ? 1 : (count_reg > MAXH) ? MAXH : int'(count_reg);
	endfunction

	function automatic void add_cmd(cmd_t c);
		cmds_to_send = {cmds_to_send, c};
	endfunction

	function automatic void shift_line(int base, int stride, int n, int a, bit toward,
			bit wrap, logic [7:0] fill);
		int s;
		bit have;
		for (int i = 0; i < n; i++) line_tmp[i] = frame_model[(base + i * stride) % STORE];
		for (int i = 0; i < n; i++) begin
			have = 1;
			s = 0;
			if (toward) begin
				s = i + a;
				if (s >= n) begin
					if (wrap) s -= n;
					else have = 0;
				end
			end else if (i >= a) begin
				s = i - a;
			end else if (wrap) begin
				s = i + n - a;
			end else begin
				have = 0;
			end
			frame_model[(base + i * stride) % STORE] = have ? line_tmp[s] : fill;
		end
	endfunction

	function automatic result_t run_command(cmd_t c);
		result_t r;
		int w, h, rw, rh, a, dir;
		bit wrap;
		w = eff_width();
		h = eff_height();
		r = '0;
		if (c.op == OP_WRITE) begin
			if (c.idx < w * h) frame_model[c.idx] = c.col;
			else r.range_error = 1'b1;
		end else if (c.op == OP_READ) begin
			if (c.idx < w * h) r.read_color = frame_model[c.idx];
			else r.range_error = 1'b1;
		end else if (c.op == OP_FILL) begin
			for (int i = 0; i < w * h; i++) frame_model[i] = c.col;
		end else if (c.op <= OP_LAST) begin
			wrap = c.op >= OP_WRAP0;
			dir = wrap ? int'(c.op - OP_WRAP0) : int'(c.op - OP_UP);
			rw = int'(c.rw);
			rh = int'(c.rh);
			if (int'(c.rx) >= w || int'(c.ry) >= h) begin
				r.range_error = 1'b1;
			end else begin
				if (rw == 0) rw = w - int'(c.rx);
				if (rh == 0) rh = h - int'(c.ry);
				if (int'(c.rx) + rw > w || int'(c.ry) + rh > h) begin
					r.range_error = 1'b1;
				end else if (dir < 2) begin
					a = (int'(c.amt) > rh) ? rh : int'(c.amt);
					if (a != 0)
						for (int i = 0; i < rw; i++)
							shift_line(int'(c.ry) * w + int'(c.rx) + i, w, rh, a, dir == 0,
								wrap, c.col);
				end else begin
					a = (int'(c.amt) > rw) ? rw : int'(c.amt);
					if (a != 0)
						for (int i = 0; i < rh; i++)
							shift_line((int'(c.ry) + i) * w + int'(c.rx), 1, rw, a, dir == 2,
								wrap, c.col);
				end
			end
		end
		return r;
	endfunction

	function automatic cmd_t pix(logic [3:0] op, int idx, int col);
		cmd_t c;
		c = '{op: op, idx: 17'(idx), rx: 9'($urandom), ry: 8'($urandom),
			rw: 10'($urandom), rh: 9'($urandom), amt: 10'($urandom), col: 8'(col)};
		return c;
	endfunction

	function automatic cmd_t rect(logic [3:0] op, int rx, int ry, int rw, int rh, int amt,
			int col);
		cmd_t c;
		c = '{op: op, idx: 17'($urandom), rx: 9'(rx), ry: 8'(ry), rw: 10'(rw),
			rh: 9'(rh), amt: 10'(amt), col: 8'(col)};
		return c;
	endfunction

	// mostly well-formed commands for the current frame, the rest raw noise
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int w, h, k, rx, ry;
		w = eff_width();
		h = eff_height();
		k = $urandom_range(0, 99);
		c = '{op: 4'($urandom), idx: 17'($urandom), rx: 9'($urandom), ry: 8'($urandom),
			rw: 10'($urandom), rh: 9'($urandom), amt: 10'($urandom), col: 8'($urandom)};
		if (k < 15) return c;
		if (k < 45) begin
			c.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			c.idx = 17'($urandom_range(0, w * h + 1));
		end else if (k < 49) begin
			c.op = OP_FILL;
		end else begin
			c.op = 4'($urandom_range(OP_UP, OP_LAST));
			rx = $urandom_range(0, w - 1);
			ry = $urandom_range(0, h - 1);
			c.rx = 9'(rx);
			c.ry = 8'(ry);
			c.rw = 10'($urandom_range(0, w - rx));
			c.rh = 9'($urandom_range(0, h - ry));
			c.amt = 10'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 512) :
				$urandom_range(0, 6));
		end
		return c;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (no_idle || k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// command driver
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				results_due = {results_due, run_command(cur)};
				n_cmds++;
				gap = pick_gap();
			end
			if (!(cmd.valid && !cmd.ready)) begin
				if (gap > 0 || cmds_to_send.size() == 0) begin
					if (gap > 0) gap--;
					cmd.valid <= 1'b0;
				end else begin
					cur = cmds_to_send.pop_front();
					cmd.operation <= cur.op;
					cmd.pixel_index <= cur.idx;
					cmd.rect_x <= cur.rx;
					cmd.rect_y <= cur.ry;
					cmd.rect_width <= cur.rw;
					cmd.rect_height <= cur.rh;
					cmd.shift_amount <= cur.amt;
					cmd.color <= cur.col;
					cmd.valid <= 1'b1;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result beat read_color=%0h range_error=%0b",
						$time, res.read_color, res.range_error);
					n_errors++;
				end else begin
					want = results_due.pop_front();
					n_checked++;
					if (want.range_error) n_flagged++;
					if (res.read_color !== want.read_color) begin
						$display("%0t: read_color expected %0h actual %0h", $time,
							want.read_color, res.read_color);
						n_errors++;
					end
					if (res.range_error !== want.range_error) begin
						$display("%0t: range_error expected %0b actual %0b", $time,
							want.range_error, res.range_error);
						n_errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				res.ready <= (stall == 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		do @(posedge clk);
		while (cmds_to_send.size() != 0 || cmd.valid || results_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [0:0] which, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (which == REG_LINE_WIDTH) width_reg = value[9:0];
		else count_reg = value[8:0];
	endtask

	task automatic set_frame(int w, int h);
		wait_drained();
		reg_write(REG_LINE_WIDTH, w);
		reg_write(REG_LINE_COUNT, h);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) add_cmd(rand_cmd());
	endtask

	initial begin
		cmd.valid = 1'b0;
		cmd.operation = '0;
		cmd.pixel_index = '0;
		cmd.rect_x = '0;
		cmd.rect_y = '0;
		cmd.rect_width = '0;
		cmd.rect_height = '0;
		cmd.shift_amount = '0;
		cmd.color = '0;
		res.ready = 1'b0;
		for (int i = 0; i < STORE; i++) frame_model[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// default 320 x 240 frame: pixel access, edge cases, every scroll kind
		add_cmd(pix(OP_WRITE, 0, 8'hFF));
		add_cmd(pix(OP_WRITE, 76799, 8'h5A));
		add_cmd(pix(OP_READ, 0, 0));
		add_cmd(pix(OP_READ, 76799, 0));
		add_cmd(pix(OP_READ, 76800, 0));
		add_cmd(pix(OP_WRITE, 131071, 8'hA5));
		for (int i = 0; i < 6; i++) add_cmd(pix(OP_WRITE, 10 + i * 321, i * 40));
		add_cmd(rect(OP_UP, 10, 10, 4, 3, 1, 8'h11));
		add_cmd(rect(OP_DOWN, 10, 10, 4, 3, 2, 8'h22));
		add_cmd(rect(OP_LEFT, 10, 10, 4, 3, 1, 8'h33));
		add_cmd(rect(OP_RIGHT, 10, 10, 4, 3, 512, 8'h44));
		add_cmd(rect(OP_UP_W, 10, 10, 5, 4, 1, 8'h55));
		add_cmd(rect(OP_DOWN_W, 10, 10, 5, 4, 3, 8'h66));
		add_cmd(rect(OP_LEFT_W, 10, 10, 5, 4, 2, 8'h77));
		add_cmd(rect(OP_RIGHT_W, 10, 10, 5, 4, 512, 8'h88));
		add_cmd(rect(OP_UP, 10, 10, 4, 3, 0, 8'h99));
		// corner outside, rectangle past the edge, zero size reaching the edges
		add_cmd(rect(OP_LEFT, 320, 0, 1, 1, 1, 0));
		add_cmd(rect(OP_DOWN, 0, 240, 1, 1, 1, 0));
		add_cmd(rect(OP_RIGHT_W, 318, 5, 4, 1, 1, 0));
		add_cmd(rect(OP_LEFT_W, 316, 236, 0, 0, 1, 0));
		add_cmd(pix(OP_SPARE_LO, 3, 8'hFF));
		add_cmd(pix(OP_SPARE_HI, 3, 8'hFF));
		add_cmd(pix(OP_FILL, 0, 8'h3C));
		add_cmd(pix(OP_READ, 12345, 0));

		// register values out of range act as 1 and as the maximum
		set_frame(0, 0);
		add_cmd(pix(OP_WRITE, 0, 8'h81));
		add_cmd(pix(OP_READ, 1, 0));
		add_cmd(rect(OP_UP_W, 0, 0, 0, 0, 1, 0));
		add_cmd(pix(OP_READ, 0, 0));
		set_frame(1023, 511);
		add_cmd(pix(OP_WRITE, 131071, 8'h7E));
		add_cmd(pix(OP_READ, 131071, 0));
		set_frame(512, 256);
		add_cmd(pix(OP_FILL, 0, 8'hC3));
		add_cmd(rect(OP_LEFT_W, 508, 252, 0, 0, 2, 0));
		add_cmd(pix(OP_READ, 131070, 0));
		set_frame(1, 1);
		queue_random(6);

		// random traffic on small frames
		for (int p = 0; p < 5; p++) begin
			set_frame($urandom_range(1, 24), $urandom_range(1, 16));
			no_idle = (p == 2);
			queue_random(12);
		end
		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d commands sent, %0d results checked (%0d flagged out of range)",
			n_cmds, n_checked, n_flagged);
		$display("frames from 1x1 to 512x256, all operations, fill and wrap scrolls");
		if (n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
